FILE: sv/arpc_pkg.sv
package arpc_pkg;

	typedef enum logic [1:0] {
		FUNC_RESOLVE = 2'd0,
		FUNC_REPLY   = 2'd1,
		FUNC_REQUEST = 2'd2,
		FUNC_TICK    = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		KIND_HIT        = 3'd0,
		KIND_PENDING    = 3'd1,
		KIND_SEND_REQ   = 3'd2,
		KIND_SEND_REPLY = 3'd3,
		KIND_RELEASE    = 3'd4,
		KIND_EXPIRED    = 3'd5,
		KIND_NO_ROOM    = 3'd6
	} kind_t;

	// configuration register indexes
	localparam logic [1:0] CFG_OWN_IP        = 2'd0;
	localparam logic [1:0] CFG_RESOLVE_TICKS = 2'd1;
	localparam logic [1:0] CFG_MAX_TRIES     = 2'd2;

	localparam int RES_CNT_W = 5;
	localparam logic [RES_CNT_W-1:0] MAX_RES = 5'd16;

	localparam int IQ_DEPTH = 2;
	localparam int IQ_PTR_W = 1;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;

	typedef struct packed {
		func_t       func;
		logic [1:0]  port;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        for_us;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [1:0]  port;
		logic [31:0] ip;
		logic [47:0] mac;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
		logic [1:0]  port;
		logic        resolved;
		logic [15:0] timer;
		logic [2:0]  tries;
	} entry_t;

endpackage

FILE: sv/arpc_front.sv
module arpc_front import arpc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [1:0]  port,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [31:0] target_ip,
	input  logic [31:0] own_ip,
	output logic        item_vld,
	output item_t       item,
	input  logic        take
);

	item_t               q_q [IQ_DEPTH];
	logic [IQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [IQ_PTR_W:0]   cnt_q;
	item_t               cls;
	logic                wr, rd;

	// classify: decode the function and check the request target here
	always_comb begin
		cls.func   = func_t'(func);
		cls.port   = port;
		cls.ip     = ip_addr;
		cls.mac    = mac_addr;
		cls.for_us = (target_ip == own_ip);
	end

	assign full     = (cnt_q == (IQ_PTR_W+1)'(IQ_DEPTH));
	assign item_vld = (cnt_q != '0);
	assign item     = q_q[rd_ptr_q];
	assign wr       = push && !full;
	assign rd       = take && item_vld;

	always_ff @(posedge clk) begin
		if (wr) q_q[wr_ptr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + IQ_PTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + IQ_PTR_W'(1);
			if (wr && !rd) cnt_q <= cnt_q + (IQ_PTR_W+1)'(1);
			else if (rd && !wr) cnt_q <= cnt_q - (IQ_PTR_W+1)'(1);
		end
	end

endmodule

FILE: sv/arpc_out_q.sv
module arpc_out_q import arpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  res_t din,
	output logic full,
	output logic empty,
	input  logic pop,
	output res_t dout
);

	res_t                q_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_PTR_W:0]   cnt_q;
	logic                wr, rd;

	assign full  = (cnt_q == (OQ_PTR_W+1)'(OQ_DEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = q_q[rd_ptr_q];
	assign wr    = push && !full;
	assign rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) q_q[wr_ptr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr) wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(1);
			if (rd) rd_ptr_q <= rd_ptr_q + OQ_PTR_W'(1);
			if (wr && !rd) cnt_q <= cnt_q + (OQ_PTR_W+1)'(1);
			else if (rd && !wr) cnt_q <= cnt_q - (OQ_PTR_W+1)'(1);
		end
	end

endmodule

FILE: sv/arpc_back.sv
module arpc_back import arpc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_vld,
	input  item_t       item,
	output logic        take,
	input  logic [15:0] resolve_ticks,
	input  logic [2:0]  max_tries,
	input  logic        out_full,
	output logic        o_push,
	output res_t        o_res
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FLUSH = 3'b100
	} st_t;

	st_t                  state_q;
	item_t                cur_q;
	logic                 iss_q;
	logic [IW-1:0]        idx_q;
	logic                 vld_s1, v_s1;
	logic [IW-1:0]        idx_s1;
	entry_t               rd_s1;
	logic                 free_vld_q;
	logic [IW-1:0]        free_idx_q;
	logic [RES_CNT_W-1:0] n_q;
	logic                 h_vld_q;
	res_t                 h_q;
	logic [ENTRIES-1:0]   valid_q;
	entry_t               mem [ENTRIES];

	logic          scan, hit, last_ent, free_any, emit, done, stall, adv, rd_en;
	logic          mem_we, set_valid, clr_valid;
	logic [IW-1:0] free_now, mem_wa;
	entry_t        mem_wd;
	res_t          e_res;

	assign scan     = (state_q == ST_SCAN);
	assign hit      = v_s1 && (rd_s1.ip == cur_q.ip) && (rd_s1.port == cur_q.port);
	assign last_ent = (idx_s1 == LAST_IDX);
	assign free_any = free_vld_q || !v_s1;
	assign free_now = free_vld_q ? free_idx_q : idx_s1;

	// evaluation of the registered entry read from the table memory
	always_comb begin
		emit      = 1'b0;
		done      = 1'b0;
		mem_we    = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		mem_wa    = idx_s1;
		mem_wd    = rd_s1;
		e_res     = '{kind: KIND_HIT, port: cur_q.port, ip: cur_q.ip, mac: '0, last: 1'b0};
		if (scan && vld_s1) begin
			if (cur_q.func == FUNC_TICK) begin
				done = last_ent;
				if (v_s1 && !rd_s1.resolved) begin
					e_res.port = rd_s1.port;
					e_res.ip   = rd_s1.ip;
					priority if (rd_s1.timer > 16'd1) begin
						mem_we       = 1'b1;
						mem_wd.timer = rd_s1.timer - 16'd1;
					end else if (n_q >= MAX_RES) begin
						mem_we       = 1'b1;
						mem_wd.timer = 16'd1;
					end else if (rd_s1.tries > 3'd1) begin
						mem_we       = 1'b1;
						mem_wd.tries = rd_s1.tries - 3'd1;
						mem_wd.timer = resolve_ticks;
						emit         = 1'b1;
						e_res.kind   = KIND_SEND_REQ;
					end else begin
						clr_valid  = 1'b1;
						emit       = 1'b1;
						e_res.kind = KIND_EXPIRED;
					end
				end
			end else if (hit) begin
				done = 1'b1;
				if (cur_q.func == FUNC_RESOLVE) begin
					emit       = 1'b1;
					e_res.kind = rd_s1.resolved ? KIND_HIT : KIND_PENDING;
					e_res.mac  = rd_s1.resolved ? rd_s1.mac : '0;
				end else begin
					mem_we          = 1'b1;
					mem_wd.mac      = cur_q.mac;
					mem_wd.resolved = 1'b1;
					if (!rd_s1.resolved) begin
						emit       = 1'b1;
						e_res.kind = KIND_RELEASE;
						e_res.mac  = cur_q.mac;
					end
				end
			end else if (last_ent) begin
				done = 1'b1;
				if (!free_any) begin
					emit       = 1'b1;
					e_res.kind = KIND_NO_ROOM;
				end else begin
					mem_we      = 1'b1;
					set_valid   = 1'b1;
					mem_wa      = free_now;
					mem_wd.ip   = cur_q.ip;
					mem_wd.port = cur_q.port;
					if (cur_q.func == FUNC_RESOLVE) begin
						mem_wd.mac      = '0;
						mem_wd.resolved = 1'b0;
						mem_wd.timer    = resolve_ticks;
						mem_wd.tries    = max_tries;
						emit            = 1'b1;
						e_res.kind      = KIND_SEND_REQ;
					end else begin
						mem_wd.mac      = cur_q.mac;
						mem_wd.resolved = 1'b1;
						mem_wd.timer    = '0;
						mem_wd.tries    = '0;
					end
				end
			end
		end
	end

	// a new result pushes the held one out, so the final one can carry last
	assign stall = emit && h_vld_q && out_full;
	assign adv   = !stall;
	assign rd_en = scan && iss_q && adv && !done;
	assign take  = (state_q == ST_IDLE) && item_vld;

	always_comb begin
		o_push = 1'b0;
		o_res  = h_q;
		if (scan && emit && h_vld_q && adv) begin
			o_push = 1'b1;
		end else if (state_q == ST_FLUSH && h_vld_q && !out_full) begin
			o_push     = 1'b1;
			o_res.last = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we && adv) mem[mem_wa] <= mem_wd;
		if (rd_en) rd_s1 <= mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (take) cur_q <= item;
		if (take && item.func == FUNC_REQUEST)
			h_q <= '{kind: KIND_SEND_REPLY, port: item.port, ip: item.ip, mac: item.mac,
				last: 1'b0};
		else if (scan && emit && adv)
			h_q <= e_res;
		if (rd_en) begin
			idx_s1 <= idx_q;
			v_s1   <= valid_q[idx_q];
		end
		if (scan && vld_s1 && adv && !v_s1 && !free_vld_q) free_idx_q <= idx_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			iss_q      <= 1'b0;
			idx_q      <= '0;
			vld_s1     <= 1'b0;
			free_vld_q <= 1'b0;
			n_q        <= '0;
			h_vld_q    <= 1'b0;
			valid_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						n_q        <= '0;
						free_vld_q <= 1'b0;
						vld_s1     <= 1'b0;
						idx_q      <= '0;
						if (item.func == FUNC_REQUEST) begin
							h_vld_q <= item.for_us;
							state_q <= ST_FLUSH;
						end else begin
							iss_q   <= 1'b1;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (adv) begin
						if (emit) begin
							h_vld_q <= 1'b1;
							n_q     <= n_q + RES_CNT_W'(1);
						end
						if (set_valid) valid_q[mem_wa] <= 1'b1;
						if (clr_valid) valid_q[mem_wa] <= 1'b0;
						if (vld_s1 && !v_s1) free_vld_q <= 1'b1;
						if (done) begin
							iss_q   <= 1'b0;
							vld_s1  <= 1'b0;
							state_q <= ST_FLUSH;
						end else begin
							vld_s1 <= iss_q;
							if (iss_q) begin
								idx_q <= idx_q + IW'(1);
								if (idx_q == LAST_IDX) iss_q <= 1'b0;
							end
						end
					end
				end
				ST_FLUSH: begin
					if (!h_vld_q) begin
						state_q <= ST_IDLE;
					end else if (!out_full) begin
						h_vld_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(o_push && out_full)) else $error("result pushed into full queue");
	a_res_limit: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= MAX_RES) else $error("too many results for one item");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !h_vld_q && !vld_s1) else $error("idle with work left");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> state_q != ST_IDLE) else $error("item taken but engine stayed idle");
`endif

endmodule

FILE: sv/arp_cache_with_retry.sv
// arp cache: a table of ENTRIES mappings keyed by port and ipv4 address
// input channel: push/full, one beat per event (resolve, reply received,
//   request received, tick); a beat is taken when push is high and full low
// result channel: empty/pop, the oldest result sits on the ports while empty
//   is low and leaves on a beat with pop high; last marks the final result
//   of one input beat, events that give no result give no beat at all
// config port: cfg_wr_en, cfg_index, cfg_wdata, written at once, only while
//   the block is idle, which the user must keep to as the block does not
//   enforce it; an index beyond max_tries is ignored
// structure: a two-deep input queue feeds a scan engine that reads one table
//   entry per cycle from the entry memory unless a full result queue stalls
//   it; a lookup that hits stops its scan early
// a result is held in the engine so last can be set, then goes to
//   a four-deep result queue; when that queue is full the scan simply waits
// reset: all entries invalid, own_ip 0, resolve_ticks 500, max_tries 3;
//   no clearing pass, the valid bits sit in flops
module arp_cache_with_retry import arpc_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [1:0]  func,
	input  logic [1:0]  port,
	input  logic [31:0] ip_addr,
	input  logic [47:0] mac_addr,
	input  logic [31:0] target_ip,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [1:0]  out_port,
	output logic [31:0] out_ip,
	output logic [47:0] out_mac,
	output logic        last,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata
);

	// configuration registers
	logic [31:0] own_ip_q;
	logic [15:0] resolve_ticks_q;
	logic [2:0]  max_tries_q;

	item_t item;
	logic  item_vld, take;
	logic  o_push, o_full;
	res_t  o_res, dout;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q        <= '0;
			resolve_ticks_q <= 16'd500;
			max_tries_q     <= 3'd3;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_OWN_IP:        own_ip_q        <= cfg_wdata;
				CFG_RESOLVE_TICKS: resolve_ticks_q <= cfg_wdata[15:0];
				CFG_MAX_TRIES:     max_tries_q     <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// front: input queue, function decode and own-ip check
	arpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.func     (func),
		.port     (port),
		.ip_addr  (ip_addr),
		.mac_addr (mac_addr),
		.target_ip(target_ip),
		.own_ip   (own_ip_q),
		.item_vld (item_vld),
		.item     (item),
		.take     (take)
	);

	// back: table memory and scan engine
	arpc_back #(.ENTRIES(ENTRIES)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_vld     (item_vld),
		.item         (item),
		.take         (take),
		.resolve_ticks(resolve_ticks_q),
		.max_tries    (max_tries_q),
		.out_full     (o_full),
		.o_push       (o_push),
		.o_res        (o_res)
	);

	// result queue decouples the engine from the consumer
	arpc_out_q u_out_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (o_push),
		.din   (o_res),
		.full  (o_full),
		.empty (empty),
		.pop   (pop),
		.dout  (dout)
	);

	assign kind     = dout.kind;
	assign out_port = dout.port;
	assign out_ip   = dout.ip;
	assign out_mac  = dout.mac;
	assign last     = dout.last;

endmodule
